[src/eor_pkg.sv]
// Shared widths, command and code types for the ellipse outline rasterizer.
// No dependencies; imported by every module of the block.
package eor_pkg;

    // field widths
    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 11;
    localparam int COLOR_BITS  = 24;
    localparam int PIX_BITS    = COORD_BITS + 2;

    // datapath widths
    localparam int SQ_BITS     = 2 * RADIUS_BITS;
    localparam int XPOS_BITS   = RADIUS_BITS + 1;
    localparam int YPOS_BITS   = RADIUS_BITS + 1;
    localparam int CUBE_BITS   = SQ_BITS + RADIUS_BITS;
    localparam int ERR_BITS    = CUBE_BITS + 7;
    localparam int CMP_BITS    = ERR_BITS + 1;
    localparam int TH_BITS     = SQ_BITS + 2;
    localparam int XPROD_BITS  = SQ_BITS + XPOS_BITS;
    localparam int YPROD_BITS  = SQ_BITS + 1 + YPOS_BITS;

    // pixels per step
    localparam int MAX_PIX      = 4;
    localparam int PIX_IDX_BITS = $clog2(MAX_PIX);

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

    // classified request as handed from front to back
    typedef struct packed {
        kind_t                  kind;
        logic [COORD_BITS-1:0]  center_x;
        logic [COORD_BITS-1:0]  center_y;
        logic [RADIUS_BITS-1:0] radius_x;
        logic [RADIUS_BITS-1:0] radius_y;
        logic [SQ_BITS-1:0]     a_sq;
        logic [SQ_BITS-1:0]     b_sq;
        logic [COLOR_BITS-1:0]  color;
    } cmd_t;

endpackage

[src/eor_front.sv]
// Front stage: accepts input requests, classifies them and squares the radii.
// Depends on eor_pkg; feeds the command queue.
module eor_front
    import eor_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic [COORD_BITS-1:0]  center_x,
    input  logic [COORD_BITS-1:0]  center_y,
    input  logic [RADIUS_BITS-1:0] radius_x,
    input  logic [RADIUS_BITS-1:0] radius_y,
    input  logic [COLOR_BITS-1:0]  color,
    output logic                   cmd_valid,
    input  logic                   cmd_ready,
    output cmd_t                   cmd
);

    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;

    // stage is free when empty or draining this cycle
    assign in_ready = !cmd_valid_reg || cmd_ready;
    assign accept   = in_valid && in_ready;

    // classify and square the radii for start requests
    always_comb
    begin
        cmd_next          = '0;
        cmd_next.kind     = kind_t'(kind);
        cmd_next.color    = color;
        cmd_next.center_x = center_x;
        cmd_next.center_y = center_y;
        cmd_next.radius_x = radius_x;
        cmd_next.radius_y = radius_y;
        if (kind_t'(kind) == KIND_START)
        begin
            cmd_next.a_sq = SQ_BITS'(radius_x) * SQ_BITS'(radius_x);
            cmd_next.b_sq = SQ_BITS'(radius_y) * SQ_BITS'(radius_y);
        end
    end

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (accept)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

[src/eor_queue.sv]
// Short command queue between the front stage and the back end.
// Depends on eor_pkg for the command type and depth.
module eor_queue
    import eor_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/eor_back.sv]
// Back end: holds the figure state, runs the error-term decision and emits
// the mirrored pixels through an output register. Depends on eor_pkg.
module eor_back
    import eor_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  cmd_t                       cmd,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [PIX_BITS-1:0] pixel_x,
    output logic signed [PIX_BITS-1:0] pixel_y,
    output logic [COLOR_BITS-1:0]      pixel_color,
    output logic                       last_of_step,
    output logic                       figure_done
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_INIT = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DEC  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   active_reg, active_next;

    // figure parameters
    logic [COORD_BITS-1:0]  cx_reg, cy_reg;
    logic [RADIUS_BITS-1:0] ra_reg, rb_reg;
    logic [COLOR_BITS-1:0]  color_reg;
    logic [SQ_BITS-1:0]     a_sq_reg, b_sq_reg;
    logic signed [TH_BITS-1:0] th1_reg, th2_reg, th3_reg;

    // iteration state
    logic [XPOS_BITS-1:0]        cur_x_reg, cur_x_next;
    logic signed [YPOS_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [ERR_BITS-1:0]  err_reg, err_next;
    logic signed [ERR_BITS-1:0]  xinc_reg, xinc_next;
    logic signed [ERR_BITS-1:0]  yinc_reg, yinc_next;

    // step pipeline
    logic [XPROD_BITS-1:0]         xprod_reg;
    logic signed [YPROD_BITS-1:0]  yprod_reg;
    logic [XPOS_BITS-1:0]          px_reg;
    logic [RADIUS_BITS-1:0]        py_reg;
    logic                          stepx_reg, stepy_reg, done_reg;
    logic                          upd1_reg, upd1_next, upd2_reg, upd2_next;
    logic [PIX_IDX_BITS-1:0]       k_reg, k_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [PIX_BITS-1:0] pixel_x_reg, pixel_y_reg;
    logic [COLOR_BITS-1:0]      color_out_reg;
    logic                       last_reg, done_out_reg;

    logic                       pop;
    logic                       load;
    logic [CUBE_BITS-1:0]       cube;
    logic signed [CMP_BITS-1:0] err_w, xprod_w, yprod_w, th1_w, th2_w, th3_w;
    logic                       c1, c2, c3, step_x, step_y;
    logic [XPOS_BITS-1:0]       new_x;
    logic signed [YPOS_BITS-1:0] new_y;
    logic                       done_w;
    logic [PIX_IDX_BITS-1:0]    last_k;
    logic                       last_w;
    logic                       plus_x, plus_y;
    logic [PIX_BITS-1:0]        base_x, base_y, off_x, off_y;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign pop       = cmd_valid && cmd_ready;
    assign load      = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // start setup product
    assign cube = CUBE_BITS'(a_sq_reg) * CUBE_BITS'(rb_reg);

    // decision rule on registered products
    assign err_w   = CMP_BITS'(err_reg);
    assign xprod_w = CMP_BITS'(xprod_reg);
    assign yprod_w = CMP_BITS'(yprod_reg);
    assign th1_w   = CMP_BITS'(th1_reg);
    assign th2_w   = CMP_BITS'(th2_reg);
    assign th3_w   = CMP_BITS'(th3_reg);
    assign c1      = (err_w + xprod_w) <= th1_w;
    assign c3      = (err_w + yprod_w) <= th3_w;
    assign c2      = (err_w - yprod_w) > th2_w;
    assign step_x  = c1 || c3 || !c2;
    assign step_y  = !(c1 || c3);
    assign new_x   = cur_x_reg + XPOS_BITS'(step_x);
    assign new_y   = cur_y_reg - $signed(YPOS_BITS'(step_y));
    assign done_w  = new_y[YPOS_BITS-1] || (new_x > XPOS_BITS'(ra_reg));

    // pixel count: one at the center, two on an axis, four otherwise
    always_comb
    begin
        if (px_reg == '0 && py_reg == '0)
        begin
            last_k = PIX_IDX_BITS'(0);
        end
        else if (px_reg == '0 || py_reg == '0)
        begin
            last_k = PIX_IDX_BITS'(1);
        end
        else
        begin
            last_k = PIX_IDX_BITS'(MAX_PIX - 1);
        end
    end
    assign last_w = (k_reg == last_k);

    // mirror select: +x on pixels 0 and 2, +y on pixels 0 and 3
    assign plus_x = (k_reg == PIX_IDX_BITS'(0)) || (k_reg == PIX_IDX_BITS'(2));
    assign plus_y = (k_reg == PIX_IDX_BITS'(0)) || (k_reg == PIX_IDX_BITS'(3));
    assign base_x = PIX_BITS'(cx_reg);
    assign base_y = PIX_BITS'(cy_reg);
    assign off_x  = PIX_BITS'(px_reg);
    assign off_y  = PIX_BITS'(py_reg);

    // sequencer and state updates
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        err_next       = err_reg;
        xinc_next      = xinc_reg;
        yinc_next      = yinc_reg;
        upd1_next      = 1'b0;
        upd2_next      = upd1_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;

        // deferred error update, x half then y half
        if (upd1_reg && stepx_reg)
        begin
            err_next = err_reg + xinc_reg;
        end
        if (upd2_reg && stepy_reg)
        begin
            err_next = err_reg + yinc_reg;
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (cmd.kind == KIND_START)
                    begin
                        state_next = ST_INIT;
                    end
                    else if (active_reg)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_INIT:
            begin
                cur_x_next  = '0;
                cur_y_next  = YPOS_BITS'(rb_reg);
                err_next    = '0 - ERR_BITS'(cube);
                xinc_next   = '0;
                yinc_next   = '0 - ERR_BITS'({cube, 1'b0});
                active_next = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_MUL:
            begin
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                cur_x_next  = new_x;
                cur_y_next  = new_y;
                if (step_x)
                begin
                    xinc_next = xinc_reg + ERR_BITS'({b_sq_reg, 1'b0});
                end
                if (step_y)
                begin
                    yinc_next = yinc_reg + ERR_BITS'({a_sq_reg, 1'b0});
                end
                active_next = !done_w;
                upd1_next   = 1'b1;
                k_next      = '0;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    k_next         = k_reg + 1'b1;
                    if (last_w)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            upd1_reg      <= 1'b0;
            upd2_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            upd1_reg      <= upd1_next;
            upd2_reg      <= upd2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        err_reg   <= err_next;
        xinc_reg  <= xinc_next;
        yinc_reg  <= yinc_next;
        k_reg     <= k_next;

        // latch a new figure
        if (pop && cmd.kind == KIND_START)
        begin
            cx_reg    <= cmd.center_x;
            cy_reg    <= cmd.center_y;
            ra_reg    <= cmd.radius_x;
            rb_reg    <= cmd.radius_y;
            color_reg <= cmd.color;
            a_sq_reg  <= cmd.a_sq;
            b_sq_reg  <= cmd.b_sq;
        end

        // decision thresholds
        if (state_reg == ST_INIT)
        begin
            th1_reg <= '0 - (TH_BITS'(a_sq_reg >> 2) + TH_BITS'(ra_reg[0]) + TH_BITS'(b_sq_reg));
            th2_reg <= '0 - (TH_BITS'(b_sq_reg >> 2) + TH_BITS'(rb_reg[0]) + TH_BITS'(a_sq_reg));
            th3_reg <= '0 - (TH_BITS'(b_sq_reg >> 2) + TH_BITS'(rb_reg[0]));
        end

        // products for the decision, old position kept for the pixels
        if (state_reg == ST_MUL)
        begin
            xprod_reg <= XPROD_BITS'(b_sq_reg) * XPROD_BITS'(cur_x_reg);
            yprod_reg <= YPROD_BITS'($signed({1'b0, a_sq_reg})) * YPROD_BITS'(cur_y_reg);
            px_reg    <= cur_x_reg;
            py_reg    <= cur_y_reg[RADIUS_BITS-1:0];
        end

        if (state_reg == ST_DEC)
        begin
            stepx_reg <= step_x;
            stepy_reg <= step_y;
            done_reg  <= done_w;
        end

        // output register
        if (load)
        begin
            pixel_x_reg   <= plus_x ? base_x + off_x : base_x - off_x;
            pixel_y_reg   <= plus_y ? base_y + off_y : base_y - off_y;
            color_out_reg <= color_reg;
            last_reg      <= last_w;
            done_out_reg  <= done_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_color  = color_out_reg;
    assign last_of_step = last_reg;
    assign figure_done  = done_out_reg;

endmodule

[src/ellipse_outline_rasterizer.sv]
// Top level of the ellipse outline rasterizer: front stage, command queue
// and back end. Depends on eor_pkg, eor_front, eor_queue and eor_back.
//
// A start request (kind 0) latches center, radii and color and sets up the
// error terms in the back end's ST_INIT state; it gives no pixel. A step request
// (kind 1) gives the 1, 2 or 4 mirrored pixels of the current point, the
// last one flagged by last_of_step, and figure_done set on every pixel of
// the step that closes the outline; a step with no figure running gives
// nothing. The back end takes a request from the queue in ST_IDLE, does the
// two squared-radius-by-position multiplies in ST_MUL and the decision in
// ST_DEC, then sends the pixels one by one through the output register in
// ST_EMIT; the front stage squares the radii and, with the two-entry queue,
// keeps accepting requests while the back end works, as long as the queue
// has room. pixel_color is registered with each pixel and holds with it
// while out_valid waits.
module ellipse_outline_rasterizer
    import eor_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic [COORD_BITS-1:0]      center_x,
    input  logic [COORD_BITS-1:0]      center_y,
    input  logic [RADIUS_BITS-1:0]     radius_x,
    input  logic [RADIUS_BITS-1:0]     radius_y,
    input  logic [COLOR_BITS-1:0]      color,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [PIX_BITS-1:0] pixel_x,
    output logic signed [PIX_BITS-1:0] pixel_y,
    output logic [COLOR_BITS-1:0]      pixel_color,
    output logic                       last_of_step,
    output logic                       figure_done
);

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic back_valid;
    logic back_ready;
    cmd_t back_cmd;

    // request intake and classification
    eor_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius_x  (radius_x),
        .radius_y  (radius_y),
        .color     (color),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // decoupling queue
    eor_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    // figure state and pixel emission
    eor_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (back_valid),
        .cmd_ready    (back_ready),
        .cmd          (back_cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_color  (pixel_color),
        .last_of_step (last_of_step),
        .figure_done  (figure_done)
    );

endmodule
